// File: hw/rtl/mqtd_pkg.sv
// Shared types and constants for the multi-queue task dispatcher.
`default_nettype none
package mqtd_pkg;
  localparam int GENERAL_QUEUES = 3;
  localparam int ID_W           = 32;
  localparam int CNT_W          = 16;
  localparam int IN_W           = 40;
  localparam int OUT_W          = 40;

  localparam logic [1:0] OP_PUSH     = 2'd0;
  localparam logic [1:0] OP_POP      = 2'd1;
  localparam logic [1:0] OP_COMPLETE = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_NONE  = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_BADQ  = 3'd3;
  localparam logic [2:0] ST_UNDER = 3'd4;

  localparam logic REG_ACTIVE_DEVICES = 1'b0;
  localparam logic REG_DEVICE_LIMIT   = 1'b1;

  localparam logic [2:0] RST_ACTIVE_DEVICES = 3'd4;
  localparam logic [7:0] RST_DEVICE_LIMIT   = 8'd5;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic pop_go;
    logic scan_last;
    logic out_free;
  } ctl_stat_t;
endpackage
`default_nettype wire

// File: hw/rtl/mqtd_ctrl.sv
// Sequencer for the dispatcher: accept, execute, scan a queue, deliver.
`default_nettype none
module mqtd_ctrl import mqtd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire ctl_stat_t stat,
  output ctl_cmd_t       cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state, state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.pop_go ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) state_next = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end
endmodule
`default_nettype wire

// File: hw/rtl/mqtd_dp.sv
// Dispatcher datapath: queue memory, fill and job counters, config, result register.
`default_nettype none
module mqtd_dp import mqtd_pkg::*; #(
  parameter int MAX_DEVICES = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IN_W-1:0]  s_tdata,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [7:0]       cfg_data,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata,
  input  wire ctl_cmd_t         cmd,
  output ctl_stat_t             stat
);
  localparam int NQ = GENERAL_QUEUES + MAX_DEVICES;
  localparam int QW = $clog2(NQ);
  localparam int UW = $clog2(NQ + 1);
  localparam int CW = (UW > 3) ? UW : 3;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int AW = $clog2(NQ * QUEUE_DEPTH);

  logic [1:0]      op_r;
  logic [2:0]      sel_r;
  logic [ID_W-1:0] id_r;
  logic [2:0]      ad_r;
  logic [7:0]      lim_r;
  logic [FW-1:0]   fill [NQ];
  logic [CNT_W-1:0] act [NQ];
  logic [ID_W-1:0] mem [NQ*QUEUE_DEPTH];
  logic [ID_W-1:0] mem_q;
  logic [IW-1:0]   didx, best_i;
  logic [ID_W-1:0] best_v;
  logic [QW-1:0]   pq;
  logic            res_g;
  logic [ID_W-1:0] res_id;
  logic [2:0]      res_q, res_st;

  logic [UW-1:0]   used;
  logic            sel_bad, full, pop_any, take, last;
  logic [QW-1:0]   sq, pq_c;
  logic [NQ-1:0]   elig;
  logic [IW-1:0]   fin_i;
  logic [ID_W-1:0] fin_v;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [ID_W-1:0] wr_data;
  logic            wr_en;

  function automatic logic [AW-1:0] qaddr(input logic [QW-1:0] q, input logic [IW-1:0] i);
    qaddr = AW'(q) * AW'(QUEUE_DEPTH) + AW'(i);
  endfunction

  always_comb begin
    if (int'(ad_r) > MAX_DEVICES) used = UW'(NQ);
    else used = UW'(GENERAL_QUEUES) + UW'(ad_r);
    sel_bad = CW'(sel_r) >= CW'(used);
    sq      = QW'(sel_r);
    full    = fill[sq] == FW'(QUEUE_DEPTH);
    for (int q = 0; q < NQ; q++) begin
      elig[q] = (UW'(q) < used) && (fill[q] != '0) && (act[q] != {CNT_W{1'b1}})
                && ((q < GENERAL_QUEUES) || (act[q] < CNT_W'(lim_r)));
    end
    pop_any = |elig;
    pq_c    = '0;
    for (int q = NQ - 1; q >= 0; q--) begin
      if (elig[q]) pq_c = QW'(q);
    end
    // running minimum over the entries read back one per cycle
    take  = (didx == '0) || (mem_q < best_v);
    fin_i = take ? didx : best_i;
    fin_v = take ? mem_q : best_v;
    last  = (FW'(didx) + FW'(1)) == fill[pq];

    rd_addr = cmd.exec ? qaddr(pq_c, '0) : qaddr(pq, didx + IW'(1));
    wr_en   = 1'b0;
    wr_addr = qaddr(sq, fill[sq][IW-1:0]);
    wr_data = id_r;
    if (cmd.exec && op_r == OP_PUSH && !sel_bad && !full) wr_en = 1'b1;
    if (cmd.scan && last) begin
      // move the last entry into the hole left by the minimum
      wr_en   = 1'b1;
      wr_addr = qaddr(pq, fin_i);
      wr_data = mem_q;
    end

    stat.pop_go    = (op_r == OP_POP) && pop_any;
    stat.scan_last = last;
    stat.out_free  = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ad_r     <= RST_ACTIVE_DEVICES;
      lim_r    <= RST_DEVICE_LIMIT;
      m_tvalid <= 1'b0;
      for (int q = 0; q < NQ; q++) begin
        fill[q] <= '0;
        act[q]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ACTIVE_DEVICES) ad_r <= cfg_data[2:0];
        else lim_r <= cfg_data;
      end
      if (cmd.load) begin
        op_r  <= s_tdata[1:0];
        sel_r <= s_tdata[4:2];
        id_r  <= s_tdata[36:5];
      end
      if (cmd.exec) begin
        res_g  <= 1'b0;
        res_id <= '0;
        res_q  <= '0;
        res_st <= ST_NONE;
        pq     <= pq_c;
        didx   <= '0;
        case (op_r)
          OP_PUSH: begin
            if (sel_bad) res_st <= ST_BADQ;
            else if (full) res_st <= ST_FULL;
            else begin
              fill[sq] <= fill[sq] + FW'(1);
              res_g    <= 1'b1;
              res_st   <= ST_OK;
            end
          end
          OP_COMPLETE: begin
            if (sel_bad) res_st <= ST_BADQ;
            else if (act[sq] == '0) res_st <= ST_UNDER;
            else begin
              act[sq] <= act[sq] - CNT_W'(1);
              res_g   <= 1'b1;
              res_st  <= ST_OK;
            end
          end
          default: ;
        endcase
      end
      if (cmd.scan) begin
        best_i <= fin_i;
        best_v <= fin_v;
        didx   <= didx + IW'(1);
        if (last) begin
          fill[pq] <= fill[pq] - FW'(1);
          act[pq]  <= act[pq] + CNT_W'(1);
          res_g    <= 1'b1;
          res_id   <= fin_v;
          res_q    <= 3'(pq);
          res_st   <= ST_OK;
        end
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {1'b0, res_st, res_q, res_id, res_g};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/multi_queue_task_dispatcher_unit.sv
// Top level of the multi-queue task dispatcher.
`default_nettype none
// The dispatcher keeps three general ready queues (misc, buffers, host) and
// MAX_DEVICES device queues, each holding up to QUEUE_DEPTH task identifiers
// in one shared on-chip memory. A push word appends a task to the named
// queue; a pop word scans the queues in index order, picks the first
// non-empty queue whose active-job count is under its limit (device queues
// use device_job_limit, general queues only saturate) and returns its
// smallest identifier; a complete word decrements a queue's active count.
// Every input word yields exactly one result word. Push, complete and
// unserved pops pass through execute to the result; a served pop also
// scans its queue, because the memory has one read port and the minimum
// search reads the chosen queue one entry per cycle. The next word is taken
// once the result is in the output register, so a stalled consumer only
// blocks the block once a second result is ready. Configuration registers
// may be written any time the block is idle; there is no memory clearing
// pass after reset.
module multi_queue_task_dispatcher_unit import mqtd_pkg::*; #(
  parameter int MAX_DEVICES = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // op[1:0], queue_sel[4:2], task_ident[36:5], zero fill[39:37]
  input  wire logic [IN_W-1:0]   s_tdata,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // granted[0], task_out_ident[32:1], task_out_queue[35:33], status[38:36], zero[39]
  output logic [OUT_W-1:0]       m_tdata,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [7:0]        cfg_data
);
  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  mqtd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mqtd_dp #(
    .MAX_DEVICES (MAX_DEVICES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );
endmodule
`default_nettype wire
